// File: hdl/lxr_pkg.sv
// ----------------------------------------------------------------------------
// Lexer package
// Character classes, scan modes, keyword matcher codes, token kinds and the
// small decode functions shared by the front and back parts of the lexer.
// ----------------------------------------------------------------------------
package lxr_pkg;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Character classes.
  localparam logic [2:0] C_BLANK  = 3'd0;
  localparam logic [2:0] C_ALPHA  = 3'd1;
  localparam logic [2:0] C_DIGIT  = 3'd2;
  localparam logic [2:0] C_LT     = 3'd3;
  localparam logic [2:0] C_GT     = 3'd4;
  localparam logic [2:0] C_DOT    = 3'd5;
  localparam logic [2:0] C_SINGLE = 3'd6;
  localparam logic [2:0] C_BAD    = 3'd7;

  // Scan modes.
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_IDENT = 3'd1;
  localparam logic [2:0] M_INT   = 3'd2;
  localparam logic [2:0] M_DOT   = 3'd3;
  localparam logic [2:0] M_FRAC  = 3'd4;
  localparam logic [2:0] M_LT    = 3'd5;
  localparam logic [2:0] M_GT    = 3'd6;
  localparam logic [2:0] M_HALT  = 3'd7;

  // Keyword prefix states.
  localparam logic [3:0] K_START = 4'd0;
  localparam logic [3:0] K_I     = 4'd1;
  localparam logic [3:0] K_IF    = 4'd2;
  localparam logic [3:0] K_IN    = 4'd3;
  localparam logic [3:0] K_INT   = 4'd4;
  localparam logic [3:0] K_E     = 4'd5;
  localparam logic [3:0] K_EL    = 4'd6;
  localparam logic [3:0] K_ELS   = 4'd7;
  localparam logic [3:0] K_ELSE  = 4'd8;
  localparam logic [3:0] K_F     = 4'd9;
  localparam logic [3:0] K_FO    = 4'd10;
  localparam logic [3:0] K_FOR   = 4'd11;
  localparam logic [3:0] K_NONE  = 4'd12;

  // Token kinds.
  localparam logic [4:0] T_ID     = 5'd0;
  localparam logic [4:0] T_NUM    = 5'd1;
  localparam logic [4:0] T_LE     = 5'd2;
  localparam logic [4:0] T_GE     = 5'd3;
  localparam logic [4:0] T_NE     = 5'd4;
  localparam logic [4:0] T_IF     = 5'd5;
  localparam logic [4:0] T_ELSE   = 5'd6;
  localparam logic [4:0] T_FOR    = 5'd7;
  localparam logic [4:0] T_INTKW  = 5'd8;
  localparam logic [4:0] T_LT     = 5'd9;
  localparam logic [4:0] T_GT     = 5'd10;
  localparam logic [4:0] T_EQ     = 5'd11;
  localparam logic [4:0] T_SEMI   = 5'd12;
  localparam logic [4:0] T_PLUS   = 5'd13;
  localparam logic [4:0] T_MINUS  = 5'd14;
  localparam logic [4:0] T_STAR   = 5'd15;
  localparam logic [4:0] T_SLASH  = 5'd16;
  localparam logic [4:0] T_LPAR   = 5'd17;
  localparam logic [4:0] T_RPAR   = 5'd18;
  localparam logic [4:0] T_END    = 5'd19;
  localparam logic [4:0] T_BAD    = 5'd20;
  localparam logic [4:0] T_DIGIT  = 5'd21;

  typedef struct packed {
    logic       eoi;
    logic [2:0] cls;
    logic [4:0] skind;
    logic [7:0] ch;
  } cls_item_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] len;
    logic       last;
  } res_t;

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h3D: k = T_EQ;
      8'h3B: k = T_SEMI;
      8'h2B: k = T_PLUS;
      8'h2D: k = T_MINUS;
      8'h2A: k = T_STAR;
      8'h2F: k = T_SLASH;
      8'h28: k = T_LPAR;
      8'h29: k = T_RPAR;
      default: k = T_ID;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] classify(input logic [7:0] c);
    logic [2:0] r;
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F) begin
      r = C_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = C_DIGIT;
    end else if (c == 8'h20 || c == 8'h0A || c == 8'h09) begin
      r = C_BLANK;
    end else if (c == 8'h3C) begin
      r = C_LT;
    end else if (c == 8'h3E) begin
      r = C_GT;
    end else if (c == 8'h2E) begin
      r = C_DOT;
    end else if (single_kind(c) != T_ID) begin
      r = C_SINGLE;
    end else begin
      r = C_BAD;
    end
    return r;
  endfunction

  function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
    logic [3:0] r;
    r = K_NONE;
    case (k)
      K_START: begin
        if (c == 8'h69) r = K_I;
        else if (c == 8'h65) r = K_E;
        else if (c == 8'h66) r = K_F;
      end
      K_I: begin
        if (c == 8'h66) r = K_IF;
        else if (c == 8'h6E) r = K_IN;
      end
      K_IN:  if (c == 8'h74) r = K_INT;
      K_E:   if (c == 8'h6C) r = K_EL;
      K_EL:  if (c == 8'h73) r = K_ELS;
      K_ELS: if (c == 8'h65) r = K_ELSE;
      K_F:   if (c == 8'h6F) r = K_FO;
      K_FO:  if (c == 8'h72) r = K_FOR;
      default: r = K_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] word_kind(input logic [3:0] k);
    logic [4:0] r;
    case (k)
      K_IF:   r = T_IF;
      K_ELSE: r = T_ELSE;
      K_FOR:  r = T_FOR;
      K_INT:  r = T_INTKW;
      default: r = T_ID;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// File: hdl/lxr_front.sv
// ----------------------------------------------------------------------------
// Lexer front
// Accepts characters, classifies each one and holds the classified items in
// a short queue that the back part drains.
// ----------------------------------------------------------------------------
module lxr_front import lxr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_input,
  output logic       in_full,
  output logic       item_valid,
  output cls_item_t  item,
  input  logic       item_pop
);

  cls_item_t           q_r [FQ_DEPTH];
  logic [FQ_AW-1:0]    wp_r, wp_nxt;
  logic [FQ_AW-1:0]    rp_r, rp_nxt;
  logic [FQ_CW-1:0]    cnt_r, cnt_nxt;
  logic                push_ok;
  logic                pop_ok;
  cls_item_t           new_item;

  assign in_full    = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rp_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = item_pop && item_valid;

  always_comb begin
    new_item.eoi   = in_end_of_input;
    new_item.cls   = classify(in_ch);
    new_item.skind = single_kind(in_ch);
    new_item.ch    = in_ch;
    wp_nxt  = push_ok ? wp_r + FQ_AW'(1) : wp_r;
    rp_nxt  = pop_ok ? rp_r + FQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + FQ_CW'(push_ok) - FQ_CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= new_item;
    end
  end

endmodule

// File: hdl/lxr_back.sv
// ----------------------------------------------------------------------------
// Lexer back
// Runs the scan state machine on classified items and writes up to two
// tokens per item into the result queue.
// ----------------------------------------------------------------------------
module lxr_back import lxr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  cls_item_t  item,
  output logic       item_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_lexeme_length,
  output logic       out_last
);

  logic [2:0]       mode_r, mode_nxt;
  logic [3:0]       kw_r, kw_nxt;
  logic [7:0]       len_r, len_nxt;
  res_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, wp_nxt;
  logic [OQ_AW-1:0] rp_r, rp_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             take;
  logic             pop_ok;
  logic [2:0]       st_mode;
  logic [3:0]       st_kw;
  logic [7:0]       st_len;
  logic             st_v;
  logic [4:0]       st_kind;
  logic             a_v, b_v;
  logic [4:0]       a_kind, b_kind;
  logic [7:0]       a_len, b_len;
  res_t             first, second;
  logic [1:0]       n_push;
  res_t             head;

  assign take     = item_valid && (cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign item_pop = take;
  assign out_empty = (cnt_r == '0);
  assign pop_ok   = out_pop && !out_empty;
  assign head     = q_r[rp_r];
  assign out_token_kind    = head.kind;
  assign out_lexeme_length = head.len;
  assign out_last          = head.last;

  always_comb begin
    st_mode = M_IDLE;
    st_kw   = K_START;
    st_len  = 8'd0;
    st_v    = 1'b0;
    st_kind = T_ID;
    case (item.cls)
      C_ALPHA: begin
        st_mode = M_IDENT;
        st_len  = 8'd1;
        st_kw   = kw_next(K_START, item.ch);
      end
      C_DIGIT: begin
        st_mode = M_INT;
        st_len  = 8'd1;
      end
      C_LT: begin
        st_mode = M_LT;
        st_len  = 8'd1;
      end
      C_GT: begin
        st_mode = M_GT;
        st_len  = 8'd1;
      end
      C_SINGLE: begin
        st_v    = 1'b1;
        st_kind = item.skind;
      end
      C_DOT, C_BAD: begin
        st_v    = 1'b1;
        st_kind = T_BAD;
        st_mode = M_HALT;
      end
      default: st_mode = M_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    kw_nxt   = kw_r;
    len_nxt  = len_r;
    a_v      = 1'b0;
    a_kind   = T_ID;
    a_len    = 8'd0;
    b_v      = 1'b0;
    b_kind   = T_ID;
    b_len    = 8'd0;
    if (take && mode_r != M_HALT) begin
      if (item.eoi) begin
        case (mode_r)
          M_IDENT: begin
            a_v = 1'b1; a_kind = word_kind(kw_r); a_len = len_r;
          end
          M_INT, M_FRAC: begin
            a_v = 1'b1; a_kind = T_NUM; a_len = len_r;
          end
          M_LT: begin
            a_v = 1'b1; a_kind = T_LT; a_len = 8'd1;
          end
          M_GT: begin
            a_v = 1'b1; a_kind = T_GT; a_len = 8'd1;
          end
          M_DOT: begin
            a_v = 1'b1; a_kind = T_DIGIT; a_len = len_r;
          end
          default: a_v = 1'b0;
        endcase
        if (mode_r == M_DOT) begin
          mode_nxt = M_HALT;
        end else begin
          b_v = 1'b1; b_kind = T_END; b_len = 8'd0;
          mode_nxt = M_IDLE;
          kw_nxt   = K_START;
          len_nxt  = 8'd0;
        end
      end else begin
        case (mode_r)
          M_IDENT: begin
            if (item.cls == C_ALPHA || item.cls == C_DIGIT) begin
              kw_nxt  = kw_next(kw_r, item.ch);
              len_nxt = sat_inc(len_r);
            end else begin
              a_v = 1'b1; a_kind = word_kind(kw_r); a_len = len_r;
              mode_nxt = st_mode; kw_nxt = st_kw; len_nxt = st_len;
              b_v = st_v; b_kind = st_kind; b_len = 8'd1;
            end
          end
          M_INT: begin
            if (item.cls == C_DIGIT) begin
              len_nxt = sat_inc(len_r);
            end else if (item.cls == C_DOT) begin
              len_nxt  = sat_inc(len_r);
              mode_nxt = M_DOT;
            end else begin
              a_v = 1'b1; a_kind = T_NUM; a_len = len_r;
              mode_nxt = st_mode; kw_nxt = st_kw; len_nxt = st_len;
              b_v = st_v; b_kind = st_kind; b_len = 8'd1;
            end
          end
          M_DOT: begin
            if (item.cls == C_DIGIT) begin
              len_nxt  = sat_inc(len_r);
              mode_nxt = M_FRAC;
            end else begin
              a_v = 1'b1; a_kind = T_DIGIT; a_len = len_r;
              mode_nxt = M_HALT;
            end
          end
          M_FRAC: begin
            if (item.cls == C_DIGIT) begin
              len_nxt = sat_inc(len_r);
            end else begin
              a_v = 1'b1; a_kind = T_NUM; a_len = len_r;
              mode_nxt = st_mode; kw_nxt = st_kw; len_nxt = st_len;
              b_v = st_v; b_kind = st_kind; b_len = 8'd1;
            end
          end
          M_LT: begin
            if (item.skind == T_EQ) begin
              a_v = 1'b1; a_kind = T_LE; a_len = 8'd2;
              mode_nxt = M_IDLE; kw_nxt = K_START; len_nxt = 8'd0;
            end else if (item.cls == C_GT) begin
              a_v = 1'b1; a_kind = T_NE; a_len = 8'd2;
              mode_nxt = M_IDLE; kw_nxt = K_START; len_nxt = 8'd0;
            end else begin
              a_v = 1'b1; a_kind = T_LT; a_len = 8'd1;
              mode_nxt = st_mode; kw_nxt = st_kw; len_nxt = st_len;
              b_v = st_v; b_kind = st_kind; b_len = 8'd1;
            end
          end
          M_GT: begin
            if (item.skind == T_EQ) begin
              a_v = 1'b1; a_kind = T_GE; a_len = 8'd2;
              mode_nxt = M_IDLE; kw_nxt = K_START; len_nxt = 8'd0;
            end else begin
              a_v = 1'b1; a_kind = T_GT; a_len = 8'd1;
              mode_nxt = st_mode; kw_nxt = st_kw; len_nxt = st_len;
              b_v = st_v; b_kind = st_kind; b_len = 8'd1;
            end
          end
          default: begin
            mode_nxt = st_mode; kw_nxt = st_kw; len_nxt = st_len;
            a_v = st_v; a_kind = st_kind; a_len = 8'd1;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (a_v) begin
      first.kind = a_kind;
      first.len  = a_len;
      first.last = !b_v;
    end else begin
      first.kind = b_kind;
      first.len  = b_len;
      first.last = 1'b1;
    end
    second.kind = b_kind;
    second.len  = b_len;
    second.last = 1'b1;
    n_push  = 2'(a_v) + 2'(b_v);
    wp_nxt  = wp_r + OQ_AW'(n_push);
    rp_nxt  = pop_ok ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + OQ_CW'(n_push) - OQ_CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      kw_r   <= K_START;
      len_r  <= 8'd0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      kw_r   <= kw_nxt;
      len_r  <= len_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wp_r] <= first;
    end
    if (n_push == 2'd2) begin
      q_r[wp_r + OQ_AW'(1)] <= second;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_HALT) |=> (mode_r == M_HALT))
    else $error("Scanner left the halted mode without reset.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CW'(OQ_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_token_kind == T_END) |-> (out_last && out_lexeme_length == 8'd0))
    else $error("End token is not the final result of its item.");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_HALT) |-> (n_push == 2'd0))
    else $error("Halted scanner produced a token.");

endmodule

// File: hdl/keyword_aware_lexer_unit.sv
// ----------------------------------------------------------------------------
// Keyword-aware lexer unit
// Scans a byte stream into tokens: identifiers, the keywords if, else, for
// and int, numbers, relational operators and single-character operators.
//
// Input channel: in_ch and in_end_of_input are taken at an edge with in_push
// high and in_full low. Result channel: while out_empty is low the oldest
// token sits on out_token_kind, out_lexeme_length and out_last; it is
// removed at an edge with out_pop high. One character gives zero, one or two
// tokens, and out_last marks the final token of that character.
// Throughput is one character per cycle while in_full is low; the result side
// drains one token per cycle, so characters that give two tokens are
// limited by out_pop. An accepted character waits in the classify queue
// until the scan state machine takes it, which needs room for two tokens,
// and writes its tokens into the result queue that drives the outputs.
// A stalled receiver backs up the result queue, then the classify queue,
// and in_full rises. A bad character, a stray dot or a missing fraction digit
// halts the scanner; later characters are accepted and dropped until reset.
// Reset empties both queues and returns the scanner to its idle mode.
// ----------------------------------------------------------------------------
module keyword_aware_lexer_unit import lxr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_input,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_lexeme_length,
  output logic       out_last
);

  logic      item_valid;
  logic      item_pop;
  cls_item_t item;

  lxr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_ch           (in_ch),
    .in_end_of_input (in_end_of_input),
    .in_full         (in_full),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop)
  );

  lxr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .item              (item),
    .item_pop          (item_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_token_kind    (out_token_kind),
    .out_lexeme_length (out_lexeme_length),
    .out_last          (out_last)
  );

endmodule

// File: test/tb_keyword_aware_lexer_unit.sv
// ----------------------------------------------------------------------------
// Keyword-aware lexer unit testbench
// Feeds character streams into the lexer and checks each token against a
// scanner model in the bench or, for typed rows, a table. The run starts with a
// short directed table, then sends random well-formed source text with noise,
// long words, long numbers and stream ends. It finishes on one halting error.
// ----------------------------------------------------------------------------
module tb_keyword_aware_lexer_unit import lxr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 1540;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    int         n;
    logic [4:0] k0;
    logic [7:0] l0;
    logic [4:0] k1;
    logic [7:0] l1;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [4:0] out_token_kind;
  logic [7:0] out_lexeme_length;
  logic       out_last;

  logic [2:0]  lex_mode = M_IDLE;
  logic [7:0]  tok_len = 8'd0;
  logic [31:0] word_txt = 32'd0;
  res_t        step_toks[$];
  res_t        typed_toks[$];
  res_t        pending_tokens[$];
  bit          use_typed = 1'b0;
  row_t        stim_rows[$];

  bit steady = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int tokens_checked = 0;
  int chars_sent = 0;
  int stream_ends = 0;

  string kw_like [16] = '{"if", "else", "for", "int", "i", "in", "e", "el", "els", "f",
                          "fo", "iff", "elsex", "for_", "int0", "IF"};
  string op_texts [13] = '{"<=", "<>", ">=", "<", ">", "=", ";", "+", "-", "*", "/",
                           "(", ")"};

  keyword_aware_lexer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .in_full          (in_full),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_lexeme_length(out_lexeme_length),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank_char(input logic [7:0] c);
    return c == " " || c == "\n" || c == "\t";
  endfunction

  function automatic logic [4:0] op_token(input logic [7:0] c);
    case (c)
      "=": return T_EQ;
      ";": return T_SEMI;
      "+": return T_PLUS;
      "-": return T_MINUS;
      "*": return T_STAR;
      "/": return T_SLASH;
      "(": return T_LPAR;
      ")": return T_RPAR;
      default: return T_ID;
    endcase
  endfunction

  function automatic bit lexable(input logic [7:0] c);
    return is_letter(c) || is_num(c) || is_blank_char(c) || c == "<" || c == ">" ||
           op_token(c) != T_ID;
  endfunction

  function automatic void put(input logic [4:0] k, input logic [7:0] l);
    res_t r;
    r.kind = k;
    r.len  = l;
    r.last = 1'b0;
    step_toks.push_back(r);
  endfunction

  function automatic void grow(input logic [7:0] c);
    if (tok_len < 8'd4) word_txt = {word_txt[23:0], c};
    if (tok_len != 8'hFF) tok_len = tok_len + 8'd1;
  endfunction

  function automatic logic [4:0] word_token();
    if (tok_len == 8'd2 && word_txt[15:0] == "if") return T_IF;
    if (tok_len == 8'd3 && word_txt[23:0] == "for") return T_FOR;
    if (tok_len == 8'd3 && word_txt[23:0] == "int") return T_INTKW;
    if (tok_len == 8'd4 && word_txt == "else") return T_ELSE;
    return T_ID;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    lex_mode = M_IDLE;
    tok_len  = 8'd0;
    word_txt = 32'd0;
    if (is_letter(c)) begin
      lex_mode = M_IDENT;
      grow(c);
    end else if (is_num(c)) begin
      lex_mode = M_INT;
      grow(c);
    end else if (c == "<") begin
      lex_mode = M_LT;
    end else if (c == ">") begin
      lex_mode = M_GT;
    end else if (op_token(c) != T_ID) begin
      put(op_token(c), 8'd1);
    end else if (!is_blank_char(c)) begin
      put(T_BAD, 8'd1);
      lex_mode = M_HALT;
    end
  endfunction

  // Advances the scanner by one character and leaves its tokens in step_toks.
  function automatic void scan_char(input logic [7:0] c, input logic eoi);
    res_t final_tok;
    step_toks.delete();
    if (lex_mode == M_HALT) return;
    if (eoi) begin
      case (lex_mode)
        M_IDENT: put(word_token(), tok_len);
        M_INT, M_FRAC: put(T_NUM, tok_len);
        M_LT: put(T_LT, 8'd1);
        M_GT: put(T_GT, 8'd1);
        M_DOT: begin
          put(T_DIGIT, tok_len);
          lex_mode = M_HALT;
        end
        default: ;
      endcase
      if (lex_mode != M_HALT) begin
        put(T_END, 8'd0);
        lex_mode = M_IDLE;
        tok_len  = 8'd0;
        word_txt = 32'd0;
      end
    end else begin
      case (lex_mode)
        M_IDENT: begin
          if (is_letter(c) || is_num(c)) begin
            grow(c);
          end else begin
            put(word_token(), tok_len);
            open_token(c);
          end
        end
        M_INT: begin
          if (is_num(c)) begin
            grow(c);
          end else if (c == ".") begin
            grow(c);
            lex_mode = M_DOT;
          end else begin
            put(T_NUM, tok_len);
            open_token(c);
          end
        end
        M_DOT: begin
          if (is_num(c)) begin
            grow(c);
            lex_mode = M_FRAC;
          end else begin
            put(T_DIGIT, tok_len);
            lex_mode = M_HALT;
          end
        end
        M_FRAC: begin
          if (is_num(c)) begin
            grow(c);
          end else begin
            put(T_NUM, tok_len);
            open_token(c);
          end
        end
        M_LT: begin
          if (c == "=") begin
            put(T_LE, 8'd2);
            lex_mode = M_IDLE;
          end else if (c == ">") begin
            put(T_NE, 8'd2);
            lex_mode = M_IDLE;
          end else begin
            put(T_LT, 8'd1);
            open_token(c);
          end
        end
        M_GT: begin
          if (c == "=") begin
            put(T_GE, 8'd2);
            lex_mode = M_IDLE;
          end else begin
            put(T_GT, 8'd1);
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
    end
    if (step_toks.size() != 0) begin
      final_tok = step_toks.pop_back();
      final_tok.last = 1'b1;
      step_toks.push_back(final_tok);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0: return " ";
      1: return "\n";
      default: return "\t";
    endcase
  endfunction

  task automatic send(input logic [7:0] c, input logic e);
    int gap;
    gap = (steady || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_ch           <= c;
    in_end_of_input <= e;
    do @(posedge clk); while (in_full);
    scan_char(c, e);
    if (use_typed) step_toks = typed_toks;
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
    chars_sent++;
    if (e) stream_ends++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(s[i], 1'b0);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] c, input logic e, input int n = -1,
                         input logic [4:0] k0 = T_ID, input logic [7:0] l0 = 8'd0,
                         input logic [4:0] k1 = T_ID, input logic [7:0] l1 = 8'd0);
    row_t r;
    r.ch  = c;
    r.eoi = e;
    r.n   = n;
    r.k0  = k0;
    r.l0  = l0;
    r.k1  = k1;
    r.l1  = l1;
    stim_rows.push_back(r);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_row(s[i], 1'b0);
  endtask

  task automatic run_rows();
    res_t t;
    foreach (stim_rows[i]) begin
      typed_toks.delete();
      use_typed = stim_rows[i].n >= 0;
      if (stim_rows[i].n > 0) begin
        t.kind = stim_rows[i].k0;
        t.len  = stim_rows[i].l0;
        t.last = stim_rows[i].n == 1;
        typed_toks.push_back(t);
      end
      if (stim_rows[i].n > 1) begin
        t.kind = stim_rows[i].k1;
        t.len  = stim_rows[i].l1;
        t.last = 1'b1;
        typed_toks.push_back(t);
      end
      send(stim_rows[i].ch, stim_rows[i].eoi);
    end
    stim_rows.delete();
    use_typed = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("token %0d: %s is %0d, expected %0d", tokens_checked, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (steady) begin
      out_pop   <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_pop   <= 1'b0;
      hold_left <= pick_gap() - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : tok_check
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_tokens.size() == 0) begin
        note_mismatch("unexpected token, kind", out_token_kind, -1);
      end else begin
        want = pending_tokens.pop_front();
        if (out_token_kind !== want.kind) note_mismatch("kind", out_token_kind, want.kind);
        if (out_lexeme_length !== want.len) begin
          note_mismatch("length", out_lexeme_length, want.len);
        end
        if (out_last !== want.last) note_mismatch("last", out_last, want.last);
      end
      tokens_checked++;
    end
  end

  initial begin
    #2_500_000;
    $display("keyword_aware_lexer_unit: mismatch");
    $finish;
  end

  initial begin
    int         pick;
    bit         frac;
    logic [7:0] c;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(8'h00, 1'b1, 1, T_END, 8'd0);
    add_text("if(else)for;int=<=<>>=_");
    add_row(8'h00, 1'b1, 2, T_ID, 8'd1, T_END, 8'd0);
    run_rows();

    for (int k = 0; chars_sent < ITEMS; k++) begin
      steady = (k % 180) >= 150;
      if (k % 90 == 45) drain();
      if (k == 120) begin
        send(rand_letter(), 1'b0);
        repeat ($urandom_range(255, 300)) begin
          send(($urandom_range(0, 1) != 0) ? rand_letter() : rand_digit(), 1'b0);
        end
        send(rand_blank(), 1'b0);
      end
      if (k == 260) begin
        send(rand_blank(), 1'b0);
        repeat ($urandom_range(256, 270)) send(rand_digit(), 1'b0);
        send(".", 1'b0);
        repeat (2) send(rand_digit(), 1'b0);
        send(rand_blank(), 1'b0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_text(kw_like[$urandom_range(0, 15)]);
      end else if (pick < 30) begin
        send(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 7)) begin
          send(($urandom_range(0, 1) != 0) ? rand_letter() : rand_digit(), 1'b0);
        end
      end else if (pick < 50) begin
        // A dot is only safe inside a number, so fractions start on a fresh token.
        frac = $urandom_range(0, 2) == 0;
        if (frac) send(rand_blank(), 1'b0);
        repeat ($urandom_range(1, 4)) send(rand_digit(), 1'b0);
        if (frac) begin
          send(".", 1'b0);
          repeat ($urandom_range(1, 3)) send(rand_digit(), 1'b0);
        end
      end else if (pick < 80) begin
        send_text(op_texts[$urandom_range(0, 12)]);
      end else if (pick < 86) begin
        send(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          do c = 8'($urandom_range(0, 127)); while (!lexable(c) || c == ".");
          send(c, 1'b0);
        end
      end
      if ($urandom_range(0, 1) == 0) send(rand_blank(), 1'b0);
    end
    steady = 1'b0;

    // The run ends on one halting error, since reset is never applied again.
    add_row(8'h00, 1'b1);
    case ($urandom_range(0, 2))
      0: begin
        do c = 8'($urandom_range(0, 255)); while (lexable(c));
        add_row(c, 1'b0, 1, T_BAD, 8'd1);
      end
      1: begin
        add_text("42.");
        add_row(8'h00, 1'b1, 1, T_DIGIT, 8'd3);
      end
      default: begin
        do c = 8'($urandom_range(0, 255)); while (is_num(c));
        add_text("42.");
        add_row(c, 1'b0, 1, T_DIGIT, 8'd3);
      end
    endcase
    add_row(8'h00, 1'b0, 0);
    add_row(8'hFF, 1'b0, 0);
    add_row("a", 1'b0, 0);
    add_row(8'hA5, 1'b1, 0);
    add_row("7", 1'b0, 0);
    run_rows();

    in_push <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d characters with %0d stream ends and checked %0d tokens,",
             chars_sent, stream_ends, tokens_checked);
    $display("including words and numbers past 255 characters and a halting error.");
    if (mismatches == 0) begin
      $display("keyword_aware_lexer_unit: match");
    end else begin
      $display("keyword_aware_lexer_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: keyword_aware_lexer_unit.f
hdl/lxr_pkg.sv
hdl/lxr_front.sv
hdl/lxr_back.sv
hdl/keyword_aware_lexer_unit.sv
test/tb_keyword_aware_lexer_unit.sv
